// ===== hdl/lvm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the look-at view matrix pipeline: widths, latencies and the
// fixed-point rounding helpers. No dependencies.
package lvm_pkg;

  localparam int unsigned CW         = 32;  // component width
  localparam int unsigned VW         = 64;  // wide vector component into a normalizer
  localparam int unsigned SQRT_STEPS = 31;  // one result bit per stage
  localparam int unsigned DIV_STEPS  = 31;  // quotient bits 30..0
  // abs/max, align, square, sum, sqrt steps, divide setup, divide steps, output
  localparam int unsigned NORM_LAT   = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int unsigned IN_W       = 9 * CW;
  localparam int unsigned OUT_W      = 12 * CW;

  localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
  localparam logic signed [63:0] MAX_S32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN_S32 = -64'sd2147483648;

  typedef logic [2:0][CW-1:0] vec3_t;
  typedef logic [2:0][VW-1:0] wvec3_t;

  // Q.60 / Q.46 down by 30 bits, half away from zero
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = (mag + (64'd1 << 29)) >> 30;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [CW-1:0] sat32(input logic signed [63:0] v);
    logic [CW-1:0] r;
    if (v < MIN_S32) begin
      r = 32'h8000_0000;
    end else if (v > MAX_S32) begin
      r = 32'h7fff_ffff;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] clamp30(input logic signed [63:0] v);
    logic [CW-1:0] r;
    if (v < -ONE_Q30) begin
      r = 32'hc000_0000;
    end else if (v > ONE_Q30) begin
      r = 32'h4000_0000;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/look_at_view_matrix.sv =====
`timescale 1ns / 1ps
// Top level of the look-at view matrix pipeline: back/side/true-up rows and
// translations from eye, target and up hint. Uses lvm_pkg and lvm_norm.
//
//  channel  | dir | width | contents
//  s_axis   | in  | 288   | eye xyz, target xyz, hint_up xyz
//  m_axis   | out | 384   | side xyz, true_up xyz, back xyz, shift xyz
//
// One transaction per cycle in each direction while the output is not stalled;
// the pipe depth comes mostly from the two normalizers (31-step square root plus 31-step divide, each).
// All stages share one enable: the pipe moves when the output register is
// empty or being taken, so a stall freezes every stage and nothing is lost.
// Reset clears only the valid bits.
module look_at_view_matrix (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, hint_up_x..z (32b each)
  input  logic [lvm_pkg::IN_W-1:0]    s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // side_x..z, true_up_x..z, back_x..z, shift_x..z (32b each)
  output logic [lvm_pkg::OUT_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned NL = lvm_pkg::NORM_LAT;

  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // stage A: eye - target
  logic [2:0][32:0]  a_diff_q;
  lvm_pkg::vec3_t    a_eye_q, a_hint_q;
  logic              a_vld_q;
  lvm_pkg::wvec3_t   n1_in;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_eye_q[i]  <= s_axis_tdata_i[32*i +: 32];
        a_hint_q[i] <= s_axis_tdata_i[32*(6+i) +: 32];
        a_diff_q[i] <= 33'($signed(s_axis_tdata_i[32*i +: 32])) -
                       33'($signed(s_axis_tdata_i[32*(3+i) +: 32]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) n1_in[i] = {{31{a_diff_q[i][32]}}, a_diff_q[i]};
  end

  logic           n1_vld;
  lvm_pkg::vec3_t n1_d;

  lvm_norm u_norm_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (a_vld_q),
    .v_i    (n1_in),
    .vld_o  (n1_vld),
    .n_o    (n1_d)
  );

  // eye and hint ride alongside the first normalizer
  logic [191:0] dl1_q [NL];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dl1_q[0] <= {a_hint_q, a_eye_q};
      for (int k = 1; k < NL; k++) dl1_q[k] <= dl1_q[k-1];
    end
  end

  lvm_pkg::vec3_t e1, h1;
  assign e1 = dl1_q[NL-1][95:0];
  assign h1 = dl1_q[NL-1][191:96];

  // C1: up hint cross back products; C2: differences
  logic signed [5:0][63:0] c1_p_q;
  lvm_pkg::vec3_t          c1_d_q, c1_e_q, c2_d_q, c2_e_q;
  lvm_pkg::wvec3_t         c2_q;
  logic                    c1_vld_q, c2_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_p_q[0] <= $signed(h1[1]) * $signed(n1_d[2]);
      c1_p_q[1] <= $signed(h1[2]) * $signed(n1_d[1]);
      c1_p_q[2] <= $signed(h1[2]) * $signed(n1_d[0]);
      c1_p_q[3] <= $signed(h1[0]) * $signed(n1_d[2]);
      c1_p_q[4] <= $signed(h1[0]) * $signed(n1_d[1]);
      c1_p_q[5] <= $signed(h1[1]) * $signed(n1_d[0]);
      c1_d_q    <= n1_d;
      c1_e_q    <= e1;
      c2_q[0]   <= c1_p_q[0] - c1_p_q[1];
      c2_q[1]   <= c1_p_q[2] - c1_p_q[3];
      c2_q[2]   <= c1_p_q[4] - c1_p_q[5];
      c2_d_q    <= c1_d_q;
      c2_e_q    <= c1_e_q;
    end
  end

  logic           n2_vld;
  lvm_pkg::vec3_t n2_s;

  lvm_norm u_norm_side (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (c2_vld_q),
    .v_i    (c2_q),
    .vld_o  (n2_vld),
    .n_o    (n2_s)
  );

  logic [191:0] dl2_q [NL];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dl2_q[0] <= {c2_e_q, c2_d_q};
      for (int k = 1; k < NL; k++) dl2_q[k] <= dl2_q[k-1];
    end
  end

  lvm_pkg::vec3_t d2, e2, f2;
  assign d2 = dl2_q[NL-1][95:0];
  assign e2 = dl2_q[NL-1][191:96];
  always_comb begin
    for (int i = 0; i < 3; i++) f2[i] = -d2[i];
  end

  // P1: products for true up and two translations
  logic signed [5:0][63:0] p1_sf_q;
  logic signed [2:0][63:0] p1_se_q, p1_fe_q;
  lvm_pkg::vec3_t          p1_s_q, p1_d_q, p1_e_q;
  logic                    p1_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_sf_q[0] <= $signed(n2_s[1]) * $signed(f2[2]);
      p1_sf_q[1] <= $signed(n2_s[2]) * $signed(f2[1]);
      p1_sf_q[2] <= $signed(n2_s[2]) * $signed(f2[0]);
      p1_sf_q[3] <= $signed(n2_s[0]) * $signed(f2[2]);
      p1_sf_q[4] <= $signed(n2_s[0]) * $signed(f2[1]);
      p1_sf_q[5] <= $signed(n2_s[1]) * $signed(f2[0]);
      for (int i = 0; i < 3; i++) begin
        p1_se_q[i] <= $signed(n2_s[i]) * $signed(e2[i]);
        p1_fe_q[i] <= $signed(f2[i]) * $signed(e2[i]);
      end
      p1_s_q <= n2_s;
      p1_d_q <= d2;
      p1_e_q <= e2;
    end
  end

  // P2: sums
  logic signed [2:0][63:0] p2_u_q;
  logic signed [63:0]      p2_tx_q, p2_tz_q;
  lvm_pkg::vec3_t          p2_s_q, p2_d_q, p2_e_q;
  logic                    p2_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_u_q[0] <= p1_sf_q[0] - p1_sf_q[1];
      p2_u_q[1] <= p1_sf_q[2] - p1_sf_q[3];
      p2_u_q[2] <= p1_sf_q[4] - p1_sf_q[5];
      p2_tx_q   <= p1_se_q[0] + p1_se_q[1] + p1_se_q[2];
      p2_tz_q   <= p1_fe_q[0] + p1_fe_q[1] + p1_fe_q[2];
      p2_s_q    <= p1_s_q;
      p2_d_q    <= p1_d_q;
      p2_e_q    <= p1_e_q;
    end
  end

  // P3: rounding and clamping
  lvm_pkg::vec3_t p3_u_q, p3_s_q, p3_d_q, p3_e_q;
  logic [31:0]    p3_shx_q, p3_shz_q;
  logic           p3_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) p3_u_q[i] <= lvm_pkg::clamp30(lvm_pkg::rnd30(p2_u_q[i]));
      p3_shx_q <= lvm_pkg::sat32(lvm_pkg::rnd30(-p2_tx_q));
      p3_shz_q <= lvm_pkg::sat32(lvm_pkg::rnd30(p2_tz_q));
      p3_s_q   <= p2_s_q;
      p3_d_q   <= p2_d_q;
      p3_e_q   <= p2_e_q;
    end
  end

  // P4: true up dot eye products; P5: sum
  logic signed [2:0][63:0] p4_ue_q;
  logic signed [63:0]      p5_ty_q;
  lvm_pkg::vec3_t          p4_u_q, p4_s_q, p4_d_q, p5_u_q, p5_s_q, p5_d_q;
  logic [31:0]             p4_shx_q, p4_shz_q, p5_shx_q, p5_shz_q;
  logic                    p4_vld_q, p5_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) p4_ue_q[i] <= $signed(p3_u_q[i]) * $signed(p3_e_q[i]);
      p4_u_q   <= p3_u_q;
      p4_s_q   <= p3_s_q;
      p4_d_q   <= p3_d_q;
      p4_shx_q <= p3_shx_q;
      p4_shz_q <= p3_shz_q;
      p5_ty_q  <= p4_ue_q[0] + p4_ue_q[1] + p4_ue_q[2];
      p5_u_q   <= p4_u_q;
      p5_s_q   <= p4_s_q;
      p5_d_q   <= p4_d_q;
      p5_shx_q <= p4_shx_q;
      p5_shz_q <= p4_shz_q;
    end
  end

  // output register
  lvm_pkg::vec3_t out_s_q, out_u_q, out_b_q;
  logic [2:0][31:0] out_sh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_s_q     <= p5_s_q;
      out_u_q     <= p5_u_q;
      out_b_q     <= p5_d_q;
      out_sh_q[0] <= p5_shx_q;
      out_sh_q[1] <= lvm_pkg::sat32(lvm_pkg::rnd30(-p5_ty_q));
      out_sh_q[2] <= p5_shz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      c1_vld_q  <= 1'b0;
      c2_vld_q  <= 1'b0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      p4_vld_q  <= 1'b0;
      p5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q   <= s_axis_tvalid_i;
      c1_vld_q  <= n1_vld;
      c2_vld_q  <= c1_vld_q;
      p1_vld_q  <= n2_vld;
      p2_vld_q  <= p1_vld_q;
      p3_vld_q  <= p2_vld_q;
      p4_vld_q  <= p3_vld_q;
      p5_vld_q  <= p4_vld_q;
      out_vld_q <= p5_vld_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_sh_q, out_b_q, out_u_q, out_s_q};

  a_back_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ($signed(out_b_q[0]) <= 32'sd1073741824 && $signed(out_b_q[0]) >= -32'sd1073741824 &&
       $signed(out_b_q[1]) <= 32'sd1073741824 && $signed(out_b_q[1]) >= -32'sd1073741824 &&
       $signed(out_b_q[2]) <= 32'sd1073741824 && $signed(out_b_q[2]) >= -32'sd1073741824))
    else $error("back row out of unit range");

  a_side_zero_up_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_s_q == '0) |-> (out_u_q == '0))
    else $error("zero side row with nonzero true up row");

  a_eye_on_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_b_q == '0) |-> (out_s_q == '0 && out_sh_q == '0))
    else $error("degenerate view gave nonzero side or translation");

endmodule

// ===== hdl/lvm_norm.sv =====
`timescale 1ns / 1ps
// Pipelined 3-vector normalizer to Q1.30: block-align, sum of squares,
// bit-serial square root and three restoring dividers. Uses lvm_pkg.
module lvm_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  lvm_pkg::wvec3_t     v_i,
  output logic                vld_o,
  output lvm_pkg::vec3_t      n_o
);

  localparam int unsigned MW = lvm_pkg::VW - 1;  // magnitudes reach 2^62
  localparam int unsigned SQ = lvm_pkg::SQRT_STEPS;
  localparam int unsigned DS = lvm_pkg::DIV_STEPS;

  typedef struct packed {
    logic [61:0]      n;
    logic [61:0]      res;
    logic [2:0][29:0] mg;
    logic [2:0]       neg;
    logic             zero;
  } sq_t;

  typedef struct packed {
    logic [2:0][60:0] rem;
    logic [30:0]      len;
    logic [2:0][30:0] quo;
    logic [2:0]       neg;
    logic             zero;
  } dv_t;

  // stage 0: sign/magnitude and largest magnitude
  logic [2:0][MW-1:0] mag0_d, mag0_q;
  logic [2:0]         neg0_q;
  logic [MW-1:0]      max0_d, max0_q;
  logic               vld0_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag0_d[i] = v_i[i][lvm_pkg::VW-1] ? MW'(-v_i[i]) : MW'(v_i[i]);
    end
    max0_d = mag0_d[0];
    if (mag0_d[1] > max0_d) max0_d = mag0_d[1];
    if (mag0_d[2] > max0_d) max0_d = mag0_d[2];
  end

  // stage 1: shift so the largest lands in [2^29, 2^30)
  logic [5:0]         lead;
  logic [2:0][MW-1:0] shr;
  logic [2:0][29:0]   mg1_d, mg1_q;
  logic [2:0]         neg1_q;
  logic               zero1_q, vld1_q;

  always_comb begin
    lead = '0;
    for (int b = 0; b < MW; b++) begin
      if (max0_q[b]) lead = 6'(b);
    end
    for (int i = 0; i < 3; i++) begin
      if (lead >= 6'd29) begin
        shr[i]   = mag0_q[i] >> (lead - 6'd29);
      end else begin
        shr[i]   = mag0_q[i] << (6'd29 - lead);
      end
      mg1_d[i] = shr[i][29:0];
    end
  end

  // stage 2: squares
  logic [2:0][59:0] sqr2_q;
  logic [2:0][29:0] mg2_q;
  logic [2:0]       neg2_q;
  logic             zero2_q, vld2_q;

  sq_t  sq_q   [SQ+1];
  logic sq_vld_q [SQ+1];
  dv_t  dv_q   [DS+1];
  logic dv_vld_q [DS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      sq_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld0_q <= vld_i;
      vld1_q <= vld0_q;
      vld2_q <= vld1_q;
      sq_vld_q[0] <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag0_q <= mag0_d;
      max0_q <= max0_d;
      for (int i = 0; i < 3; i++) neg0_q[i] <= v_i[i][lvm_pkg::VW-1];
      mg1_q   <= mg1_d;
      neg1_q  <= neg0_q;
      zero1_q <= (max0_q == '0);
      for (int i = 0; i < 3; i++) sqr2_q[i] <= mg1_q[i] * mg1_q[i];
      mg2_q   <= mg1_q;
      neg2_q  <= neg1_q;
      zero2_q <= zero1_q;
      sq_q[0].n    <= 62'(sqr2_q[0]) + 62'(sqr2_q[1]) + 62'(sqr2_q[2]);
      sq_q[0].res  <= '0;
      sq_q[0].mg   <= mg2_q;
      sq_q[0].neg  <= neg2_q;
      sq_q[0].zero <= zero2_q;
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam int unsigned SH = 60 - 2 * k;
    localparam logic [61:0] BIT = 62'd1 << SH;
    logic [61:0] trial;
    sq_t         nx;

    always_comb begin
      nx    = sq_q[k];
      trial = sq_q[k].res + BIT;
      if (sq_q[k].n >= trial) begin
        nx.n   = sq_q[k].n - trial;
        nx.res = (sq_q[k].res >> 1) + BIT;
      end else begin
        nx.res = sq_q[k].res >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) sq_q[k+1] <= nx;
    end
  end

  // divider set-up: numerator mg * 2^30 + len/2
  logic [30:0] len;
  assign len = sq_q[SQ].res[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_vld_q[0] <= sq_vld_q[SQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_q[0].rem[i] <= {1'b0, sq_q[SQ].mg[i], 30'd0} + 61'(len >> 1);
      end
      dv_q[0].len  <= len;
      dv_q[0].quo  <= '0;
      dv_q[0].neg  <= sq_q[SQ].neg;
      dv_q[0].zero <= sq_q[SQ].zero;
    end
  end

  // restoring division, one quotient bit per stage for all three lanes
  for (genvar k = 0; k < DS; k++) begin : g_div
    localparam int unsigned J = DS - 1 - k;
    logic [60:0] dvs;
    dv_t         nx;

    always_comb begin
      nx  = dv_q[k];
      dvs = 61'(dv_q[k].len) << J;
      for (int i = 0; i < 3; i++) begin
        if (dv_q[k].rem[i] >= dvs) begin
          nx.rem[i]    = dv_q[k].rem[i] - dvs;
          nx.quo[i][J] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) dv_q[k+1] <= nx;
    end
  end

  // output: reapply sign, zero-length vector gives zero
  lvm_pkg::vec3_t n_q;
  logic           vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= dv_vld_q[DS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_q[DS].zero) begin
          n_q[i] <= '0;
        end else if (dv_q[DS].neg[i]) begin
          n_q[i] <= -(32'(dv_q[DS].quo[i]));
        end else begin
          n_q[i] <= 32'(dv_q[DS].quo[i]);
        end
      end
    end
  end

  assign vld_o = vld_q;
  assign n_o   = n_q;

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> ($signed(n_o[0]) <= 32'sd1073741824 && $signed(n_o[0]) >= -32'sd1073741824 &&
               $signed(n_o[1]) <= 32'sd1073741824 && $signed(n_o[1]) >= -32'sd1073741824 &&
               $signed(n_o[2]) <= 32'sd1073741824 && $signed(n_o[2]) >= -32'sd1073741824))
    else $error("normalized component out of Q1.30 unit range");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(vld_o))
    else $error("output valid moved while the pipe was stalled");

endmodule
